// ===== hdl/rc_pulse_to_pwm_duty_unit_macros.svh =====
// Assertion macros shared by the RC pulse to PWM duty unit
`ifndef RC_PULSE_TO_PWM_DUTY_UNIT_MACROS_SVH
`define RC_PULSE_TO_PWM_DUTY_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define RPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define RPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/rpd_pkg.sv =====
// Package: types, constants and register map of the RC pulse to PWM duty unit
`default_nettype none

package rpd_pkg;

    // Field widths
    localparam int PW_W     = 16;   // pulse width in us
    localparam int DUTY_W   = 7;    // duty in percent
    localparam int CMPV_W   = 16;   // PWM compare value
    localparam int CFG_W    = 16;   // wide config registers
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 5;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // Default counter width of the silence counter
    localparam int COUNT_WIDTH_DEF = 16;

    // Pulse range for linear mode
    localparam logic [PW_W-1:0] PULSE_MIN_US = 16'd1000;
    localparam logic [PW_W-1:0] PULSE_MAX_US = 16'd2000;
    localparam logic [DUTY_W-1:0] DUTY_FULL  = 7'd100;

    // Linear scale: product (width-1000)*max_duty, 10 x 7 bits
    localparam int LIN_D_W    = 10;
    localparam int LIN_PROD_W = LIN_D_W + DUTY_W;

    // Divide by 1000 through a floor reciprocal, one correction step after
    localparam int                DIV1000_SHIFT = 27;
    localparam int                DIV1000_MW    = 18;
    localparam logic [DIV1000_MW-1:0] DIV1000_MUL = 18'd134217;

    // Compare product duty*(period+1) fits 23 bits (100*65536)
    localparam int CMP_PROD_W = 23;
    localparam int CMP_Q_W    = 17;

    // Divide by 100 through a floor reciprocal, one correction step after
    localparam int                DIV100_SHIFT = 30;
    localparam int                DIV100_MW    = 24;
    localparam logic [DIV100_MW-1:0] DIV100_MUL = 24'd10737418;

    // Register reset values
    localparam logic [DUTY_W-1:0] RST_MAX_DUTY = 7'd60;
    localparam logic [CFG_W-1:0]  RST_PERIOD   = 16'd11999;
    localparam logic [CFG_W-1:0]  RST_ON_THR   = 16'd1550;
    localparam logic [CFG_W-1:0]  RST_OFF_THR  = 16'd1450;
    localparam logic [CFG_W-1:0]  RST_TIMEOUT  = 16'd500;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_DIM_MODE    = 3'd0,
        REG_FAILSAFE_ON = 3'd1,
        REG_MAX_DUTY    = 3'd2,
        REG_PWM_PERIOD  = 3'd3,
        REG_ON_THR      = 3'd4,
        REG_OFF_THR     = 3'd5,
        REG_TIMEOUT     = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic              dim_mode;
        logic              failsafe_on;
        logic [DUTY_W-1:0] max_duty;
        logic [CFG_W-1:0]  pwm_period;
        logic [CFG_W-1:0]  on_thr;
        logic [CFG_W-1:0]  off_thr;
        logic [CFG_W-1:0]  timeout;
    } t_cfg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DIV_W,
        ST_UPDATE,
        ST_CMP_MUL,
        ST_CMP_DIV,
        ST_FINISH
    } t_state;

    // Datapath step enables
    typedef struct packed {
        logic load_in;
        logic scale;
        logic div_w;
        logic update;
        logic cmp_mul;
        logic cmp_div;
        logic finish;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== hdl/rpd_cfg_regs.sv =====
// APB register file of the RC pulse to PWM duty unit
`default_nettype none

module rpd_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rpd_pkg::APB_AW-1:0] paddr,
    input  wire logic [rpd_pkg::APB_DW-1:0] pwdata,
    output logic      [rpd_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output rpd_pkg::t_cfg                   o_cfg
);
    import rpd_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dim_mode    <= 1'b0;
            r_cfg.failsafe_on <= 1'b0;
            r_cfg.max_duty    <= RST_MAX_DUTY;
            r_cfg.pwm_period  <= RST_PERIOD;
            r_cfg.on_thr      <= RST_ON_THR;
            r_cfg.off_thr     <= RST_OFF_THR;
            r_cfg.timeout     <= RST_TIMEOUT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DIM_MODE:    r_cfg.dim_mode    <= pwdata[0];
                REG_FAILSAFE_ON: r_cfg.failsafe_on <= pwdata[0];
                REG_MAX_DUTY:    r_cfg.max_duty    <= pwdata[DUTY_W-1:0];
                REG_PWM_PERIOD:  r_cfg.pwm_period  <= pwdata[CFG_W-1:0];
                REG_ON_THR:      r_cfg.on_thr      <= pwdata[CFG_W-1:0];
                REG_OFF_THR:     r_cfg.off_thr     <= pwdata[CFG_W-1:0];
                REG_TIMEOUT:     r_cfg.timeout     <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            REG_DIM_MODE:    prdata = APB_DW'(r_cfg.dim_mode);
            REG_FAILSAFE_ON: prdata = APB_DW'(r_cfg.failsafe_on);
            REG_MAX_DUTY:    prdata = APB_DW'(r_cfg.max_duty);
            REG_PWM_PERIOD:  prdata = APB_DW'(r_cfg.pwm_period);
            REG_ON_THR:      prdata = APB_DW'(r_cfg.on_thr);
            REG_OFF_THR:     prdata = APB_DW'(r_cfg.off_thr);
            REG_TIMEOUT:     prdata = APB_DW'(r_cfg.timeout);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/rpd_ctrl.sv =====
// Sequencer of the RC pulse to PWM duty unit: handshakes and step enables
`default_nettype none

module rpd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_valid,
    output logic               o_s_ready,
    output logic               o_m_valid,
    input  wire logic          i_m_ready,
    output rpd_pkg::t_dp_cmd   o_cmd
);
    import rpd_pkg::*;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    logic   slot_free;

    assign slot_free = !r_m_valid || i_m_ready;
    assign o_m_valid = r_m_valid;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    // Next state and step enables
    always_comb begin
        n_state   = r_state;
        n_m_valid = r_m_valid && !i_m_ready;
        o_s_ready = 1'b0;
        o_cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_ready     = 1'b1;
                o_cmd.load_in = i_s_valid;
                if (i_s_valid) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_DIV_W;
            end
            ST_DIV_W: begin
                o_cmd.div_w = 1'b1;
                n_state     = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_CMP_MUL;
            end
            ST_CMP_MUL: begin
                o_cmd.cmp_mul = 1'b1;
                n_state       = ST_CMP_DIV;
            end
            ST_CMP_DIV: begin
                o_cmd.cmp_div = 1'b1;
                n_state       = ST_FINISH;
            end
            ST_FINISH: begin
                // wait here until the output register can take the result
                if (slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_m_valid    = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/rpd_datapath.sv =====
// Datapath of the RC pulse to PWM duty unit: duty state, scaling, compare value
`default_nettype none

module rpd_datapath #(
    parameter int COUNT_WIDTH = rpd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rpd_pkg::t_dp_cmd              i_cmd,
    input  wire rpd_pkg::t_cfg                 i_cfg,
    input  wire logic                          i_new_pulse,
    input  wire logic [rpd_pkg::PW_W-1:0]      i_pulse_width_us,
    output logic      [rpd_pkg::CMPV_W-1:0]    o_compare_value,
    output logic      [rpd_pkg::DUTY_W-1:0]    o_duty_percent,
    output logic                               o_signal_lost
);
    import rpd_pkg::*;

    localparam int CNT_CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
    localparam int LIN_MF_W  = LIN_PROD_W + DIV1000_MW;
    localparam int CMP_MF_W  = CMP_PROD_W + DIV100_MW;

    // Item registers
    logic                   r_pulse;
    logic [PW_W-1:0]        r_width;
    logic [LIN_PROD_W-1:0]  r_lin_prod;
    logic [DUTY_W-1:0]      r_lin_q0;
    logic [CMP_PROD_W-1:0]  r_cmp_prod;
    logic [CMP_Q_W-1:0]     r_cmp_q0;

    // Unit state
    logic                   r_switch_on, n_switch_on;
    logic [COUNT_WIDTH-1:0] r_silence, n_silence;
    logic                   r_timed_out, n_timed_out;
    logic [DUTY_W-1:0]      r_held_duty, n_held_duty;

    logic [PW_W-1:0]        width_off;
    logic [LIN_MF_W-1:0]    lin_mul_full;
    logic [LIN_PROD_W-1:0]  lin_back;
    logic [LIN_PROD_W-1:0]  lin_rem;
    logic [DUTY_W:0]        lin_q;
    logic [DUTY_W-1:0]      lin_duty;
    logic [DUTY_W-1:0]      full_duty;
    logic [COUNT_WIDTH-1:0] silence_inc;
    logic [CMP_MF_W-1:0]    cmp_mul_full;
    logic [CMP_PROD_W-1:0]  cmp_back;
    logic [CMP_PROD_W-1:0]  cmp_rem;
    logic [CMP_Q_W-1:0]     cmp_q;
    logic [CMPV_W-1:0]      cmp_sat;

    assign full_duty = (i_cfg.max_duty > DUTY_FULL) ? DUTY_FULL : i_cfg.max_duty;

    // Linear scale and reciprocal divide by 1000
    assign width_off    = r_width - PULSE_MIN_US;
    assign lin_mul_full = LIN_MF_W'(r_lin_prod) * LIN_MF_W'(DIV1000_MUL);
    assign lin_back     = LIN_PROD_W'(r_lin_q0) * LIN_PROD_W'(10'd1000);
    assign lin_rem      = r_lin_prod - lin_back;
    assign lin_q        = {1'b0, r_lin_q0} + (DUTY_W+1)'(lin_rem >= LIN_PROD_W'(1000));
    assign lin_duty     = (lin_q > (DUTY_W+1)'(DUTY_FULL)) ? DUTY_FULL : lin_q[DUTY_W-1:0];

    // Saturating silence count
    assign silence_inc = (&r_silence) ? r_silence : r_silence + 1'b1;

    // State update for one tick
    always_comb begin
        n_switch_on = r_switch_on;
        n_silence   = r_silence;
        n_timed_out = r_timed_out;
        n_held_duty = r_held_duty;
        if (r_pulse) begin
            n_timed_out = 1'b0;
            n_silence   = '0;
            if (i_cfg.dim_mode) begin
                priority if (r_width <= PULSE_MIN_US) begin
                    n_held_duty = '0;
                end else if (r_width >= PULSE_MAX_US) begin
                    n_held_duty = full_duty;
                end else begin
                    n_held_duty = lin_duty;
                end
            end else begin
                // on test first, so crossed thresholds still switch on
                priority if (r_width >= i_cfg.on_thr) begin
                    n_switch_on = 1'b1;
                end else if (r_width < i_cfg.off_thr) begin
                    n_switch_on = 1'b0;
                end else begin
                    n_switch_on = r_switch_on;
                end
                n_held_duty = n_switch_on ? full_duty : '0;
            end
        end else begin
            n_silence = silence_inc;
            if (CNT_CMP_W'(silence_inc) >= CNT_CMP_W'(i_cfg.timeout)) begin
                n_timed_out = 1'b1;
            end
        end
        if (n_timed_out) begin
            n_held_duty = i_cfg.failsafe_on ? full_duty : '0;
        end
    end

    // Compare value: reciprocal divide by 100 with one correction
    assign cmp_mul_full = CMP_MF_W'(r_cmp_prod) * CMP_MF_W'(DIV100_MUL);
    assign cmp_back     = CMP_PROD_W'(r_cmp_q0) * CMP_PROD_W'(7'd100);
    assign cmp_rem      = r_cmp_prod - cmp_back;
    assign cmp_q        = r_cmp_q0 + CMP_Q_W'(cmp_rem >= CMP_PROD_W'(100));
    assign cmp_sat      = cmp_q[CMP_Q_W-1] ? {CMPV_W{1'b1}} : cmp_q[CMPV_W-1:0];

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_switch_on <= 1'b0;
            r_silence   <= '0;
            r_timed_out <= 1'b0;
            r_held_duty <= '0;
        end else if (i_cmd.update) begin
            r_switch_on <= n_switch_on;
            r_silence   <= n_silence;
            r_timed_out <= n_timed_out;
            r_held_duty <= n_held_duty;
        end
    end

    // Work registers, one step each
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_pulse <= i_new_pulse;
            r_width <= i_pulse_width_us;
        end
        if (i_cmd.scale) begin
            r_lin_prod <= LIN_PROD_W'(width_off[LIN_D_W-1:0]) * LIN_PROD_W'(i_cfg.max_duty);
        end
        if (i_cmd.div_w) begin
            r_lin_q0 <= lin_mul_full[DIV1000_SHIFT +: DUTY_W];
        end
        if (i_cmd.cmp_mul) begin
            r_cmp_prod <= CMP_PROD_W'(r_held_duty)
                          * CMP_PROD_W'({1'b0, i_cfg.pwm_period} + 17'd1);
        end
        if (i_cmd.cmp_div) begin
            r_cmp_q0 <= cmp_mul_full[DIV100_SHIFT +: CMP_Q_W];
        end
        if (i_cmd.finish) begin
            o_compare_value <= cmp_sat;
            o_duty_percent  <= r_held_duty;
            o_signal_lost   <= r_timed_out;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rc_pulse_to_pwm_duty_unit.sv =====
// Top level of the RC pulse to PWM duty unit
//
//  port group      dir  transfer                  payload
//  s_axis_*        in   s_axis_tvalid&tready      tdata: pulse_width_us, tuser: new_pulse
//  m_axis_*        out  m_axis_tvalid&tready      tdata: compare_value, duty_percent
//                                                 tuser: signal_lost
//  APB             in   psel&penable&pwrite       7 registers at 4*index
//
// A new item is taken only in the idle state, so only after the last result is in the output register.
// The sequencer steps two multiply/reciprocal-divide chains
// (duty scale by 1000, then compare by 100) through one datapath.
// A result waits in the output register; a stalled output holds the sequencer
// in its last step. Synchronous active-low reset sets state and config to their reset values.
`default_nettype none
`include "rc_pulse_to_pwm_duty_unit_macros.svh"

module rc_pulse_to_pwm_duty_unit #(
    parameter int COUNT_WIDTH = rpd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [rpd_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [15:0] pulse_width_us
    input  wire logic                            s_axis_tuser,  // [0] new_pulse
    // master stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [rpd_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // [15:0] compare_value,
                                                                // [22:16] duty_percent
    output logic                                 m_axis_tuser,  // [0] signal_lost
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rpd_pkg::APB_AW-1:0]      paddr,
    input  wire logic [rpd_pkg::APB_DW-1:0]      pwdata,
    output logic      [rpd_pkg::APB_DW-1:0]      prdata,
    output logic                                 pready
);
    import rpd_pkg::*;

    t_cfg              cfg;
    t_dp_cmd           cmd;
    logic [CMPV_W-1:0] compare_value;
    logic [DUTY_W-1:0] duty_percent;
    logic              signal_lost;
    logic              in_xfer;
    logic              zero_duty;

    rpd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rpd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (cmd)
    );

    rpd_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg            (cfg),
        .i_new_pulse      (s_axis_tuser),
        .i_pulse_width_us (s_axis_tdata[PW_W-1:0]),
        .o_compare_value  (compare_value),
        .o_duty_percent   (duty_percent),
        .o_signal_lost    (signal_lost)
    );

    // Output packing
    assign m_axis_tdata = {{(M_TDATA_W-CMPV_W-DUTY_W){1'b0}}, duty_percent, compare_value};
    assign m_axis_tuser = signal_lost;

    // Checks
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign zero_duty = m_axis_tvalid && (duty_percent == '0);

    `RPD_ASSERT_NEXT(a_busy_after_in, in_xfer, !s_axis_tready, "input taken while busy")
    `RPD_ASSERT_NOW(a_duty_range, m_axis_tvalid, duty_percent <= DUTY_FULL, "duty above 100")
    `RPD_ASSERT_NOW(a_zero_duty_cmp, zero_duty, compare_value == '0, "zero duty, nonzero cmp")

endmodule

`default_nettype wire
